// ===== design/assert_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define OLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define OLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/oll_pkg.sv =====
// Types and constants for the ordered list engine.
// Used by oll_cell, oll_out_buf, ordered_list_engine_core, list_result_checker and tb_top; depends on nothing.
package oll_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_READ_FRONT = 4'd4,
    CMD_READ_BACK  = 4'd5,
    CMD_INSERT     = 4'd6,
    CMD_REMOVE     = 4'd7,
    CMD_FIND       = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_GATHER = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     find;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_GATHER = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  position;
    status_t     status;
    logic [4:0]  count;
  } result_t;

  localparam logic [31:0] VALUE_EMPTY = 32'hFFFF_FFFF;

endpackage

// ===== design/oll_cell.sv =====
// One storage cell of the ordered list chain, with its stage of the gather chain.
// Depends on oll_pkg.
module oll_cell #(
  parameter int IDX = 0,
  parameter int DW  = 32,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  oll_pkg::cell_ctl_t  ctl,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       cnt,
  input  logic [DW-1:0]       word,
  input  logic [DW-1:0]       left_entry,
  input  logic [DW-1:0]       right_entry,
  input  logic                right_hit,
  input  logic [DW-1:0]       right_data,
  output logic [DW-1:0]       entry,
  output logic                hit,
  output logic [DW-1:0]       data
);
  import oll_pkg::*;

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic [DW-1:0] entry_next;
  logic          sel;
  logic [DW-1:0] pick;

  always_comb begin
    // In find mode an occupied cell that holds the word offers its own index; otherwise
    // the last occupied cell offers its word. The lowest offering cell wins down the chain.
    sel  = ctl.find ? ((MY_IDX < cnt) && (entry == word)) : (MY_NEXT == cnt);
    pick = ctl.find ? DW'(IDX) : entry;
    entry_next = entry;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (MY_IDX > pos) begin
          entry_next = left_entry;
        end else if (MY_IDX == pos) begin
          entry_next = word;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.op == CELL_GATHER) begin
      hit  <= sel ? 1'b1 : right_hit;
      data <= sel ? pick : right_data;
    end
  end

endmodule

// ===== design/oll_out_buf.sv =====
// Two-entry result buffer that decouples the result port from the list logic.
// Depends on oll_pkg.
module oll_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  oll_pkg::result_t  push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output oll_pkg::result_t  out_data,
  output logic              room
);
  import oll_pkg::*;

  logic    head_valid;
  logic    spare_valid;
  result_t head;
  result_t spare;
  logic    pop;

  assign pop       = head_valid && out_ready;
  assign out_valid = head_valid;
  assign out_data  = head;
  assign room      = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        head_valid  <= 1'b1;
        spare_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        spare_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_valid) begin
        head <= spare;
        if (push) begin
          spare <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        spare <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

endmodule

// ===== design/ordered_list_engine_core.sv =====
// Top level of the ordered list engine: a chain of cells plus the command sequencer.
// Depends on oll_pkg, oll_cell, oll_out_buf and assert_macros.svh.
//
// A bounded ordered list of up to CAPACITY words of DATA_WIDTH bits, held in a
// row of cells with entry 0 at the front. Every command beat gives exactly one
// result beat. Push, insert, pop front, read front, remove, unknown commands and
// any back access on an empty list finish in the cycle they are taken, and their
// result is registered into the output buffer. Pop back, read back and find keep the
// sequencer busy: the cycle they are taken, then the gather state while the
// answer ripples one cell per cycle down the gather chain from the far end of the
// row to cell 0, then a final state that forms the result. The sequencer is back in
// idle as the result is registered, and the next command is taken once the buffer
// has room. One command is worked on at a time; a new command is taken while up
// to one finished result still waits at the output.
module ordered_list_engine_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         command,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [4:0]         result_position,
  output logic [2:0]         status,
  output logic [4:0]         item_count
);
  import oll_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  state_t                state;
  state_t                state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [IW-1:0]         gcnt;
  logic [IW-1:0]         gcnt_next;
  cmd_t                  op_cmd;
  logic [DATA_WIDTH-1:0] key;

  logic                  accept;
  logic                  latch;
  logic                  room;
  logic                  push;
  result_t               res;
  result_t               buf_data;
  cell_ctl_t             cctl;
  logic [CW-1:0]         cpos;
  logic [DATA_WIDTH-1:0] cword;

  logic [XW-1:0]         val_x;
  logic [DATA_WIDTH-1:0] word_in;
  logic [XW-1:0]         front_x;
  logic [XW-1:0]         gath_x;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [CW-1:0]         ins_p;
  logic                  full;
  logic                  empty;
  cmd_t                  cmd;

  logic [DATA_WIDTH-1:0] ent   [CAPACITY];
  logic                  ghit  [CAPACITY];
  logic [DATA_WIDTH-1:0] gdata [CAPACITY];

  // Stored words keep the low bits (zero-extended when wider than the port);
  // words read back are sign-extended from the stored width.
  assign val_x   = XW'($unsigned(value));
  assign word_in = val_x[DATA_WIDTH-1:0];
  assign front_x = XW'($signed(ent[0]));
  assign gath_x  = XW'($signed(gdata[0]));

  assign pos_x = PW'(position);
  assign cnt_x = PW'(count);
  assign ins_p = (pos_x >= cnt_x) ? count : CW'(position);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign cmd   = cmd_t'(command);

  assign in_ready = (state == S_IDLE) && room;
  assign accept   = in_valid && in_ready;
  assign cword    = (state == S_IDLE) ? word_in : key;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      gcnt  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      gcnt  <= gcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      op_cmd <= cmd;
      key    <= word_in;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    gcnt_next    = '0;
    latch        = 1'b0;
    push         = 1'b0;
    cctl.op      = CELL_HOLD;
    cctl.find    = (op_cmd == CMD_FIND);
    cpos         = '0;
    res.value    = '0;
    res.position = '0;
    res.status   = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                cctl.op    = CELL_INSERT;
                count_next = count + 1'b1;
                if (cmd == CMD_PUSH_FRONT) begin
                  cpos = '0;
                end else if (cmd == CMD_PUSH_BACK) begin
                  cpos = count;
                end else begin
                  cpos = ins_p;
                end
              end
            end
            CMD_POP_FRONT, CMD_READ_FRONT: begin
              if (empty) begin
                res.value  = VALUE_EMPTY;
                res.status = STAT_EMPTY;
              end else begin
                res.value = front_x[31:0];
                if (cmd == CMD_POP_FRONT) begin
                  cctl.op    = CELL_REMOVE;
                  count_next = count - 1'b1;
                end
              end
            end
            CMD_POP_BACK, CMD_READ_BACK: begin
              if (empty) begin
                res.value  = VALUE_EMPTY;
                res.status = STAT_EMPTY;
              end else begin
                push       = 1'b0;
                latch      = 1'b1;
                state_next = S_GATHER;
              end
            end
            CMD_REMOVE: begin
              if (pos_x >= cnt_x) begin
                res.status = STAT_RANGE;
              end else begin
                cctl.op    = CELL_REMOVE;
                cpos       = CW'(position);
                count_next = count - 1'b1;
              end
            end
            CMD_FIND: begin
              push       = 1'b0;
              latch      = 1'b1;
              state_next = S_GATHER;
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end
      S_GATHER: begin
        cctl.op   = CELL_GATHER;
        gcnt_next = gcnt + 1'b1;
        if (gcnt == IW'(CAPACITY - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        push       = 1'b1;
        state_next = S_IDLE;
        if (op_cmd == CMD_FIND) begin
          if (ghit[0]) begin
            res.position = 5'(gdata[0][IW-1:0]);
          end else begin
            res.position = 5'(count);
            res.status   = STAT_NOT_FOUND;
          end
        end else begin
          res.value = gath_x[31:0];
          if (op_cmd == CMD_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.count = 5'(count_next);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    logic                  rhit_w;
    logic [DATA_WIDTH-1:0] rdata_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
      assign rhit_w  = 1'b0;
      assign rdata_w = '0;
    end else begin : g_inner_r
      assign right_w = ent[i+1];
      assign rhit_w  = ghit[i+1];
      assign rdata_w = gdata[i+1];
    end

    oll_cell #(
      .IDX (i),
      .DW  (DATA_WIDTH),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (cctl),
      .pos         (cpos),
      .cnt         (count),
      .word        (cword),
      .left_entry  (left_w),
      .right_entry (right_w),
      .right_hit   (rhit_w),
      .right_data  (rdata_w),
      .entry       (ent[i]),
      .hit         (ghit[i]),
      .data        (gdata[i])
    );
  end

  oll_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (buf_data),
    .room      (room)
  );

  assign result_value    = buf_data.value;
  assign result_position = buf_data.position;
  assign status          = buf_data.status;
  assign item_count      = buf_data.count;

  `include "assert_macros.svh"

  // A result is only produced when the buffer can hold it.
  `OLL_ASSERT(a_push_has_room, !push || room || (out_valid && out_ready), "result beat overflow")
  // The list never grows past its bound.
  `OLL_ASSERT_ALWAYS(a_count_bound, rst || (count <= CW'(CAPACITY)), "count above capacity")
  // A single command changes the count by at most one.
  `OLL_ASSERT(a_count_step, (count == $past(count)) || (count == CW'($past(count) + 1'b1)) || (count == CW'($past(count) - 1'b1)), "count jumped")

endmodule

// ===== sim/list_result_checker.sv =====
// Checker for ordered_list_engine_core: mirrors the list contents and compares each result beat.
// Depends on oll_pkg; instantiated by tb_top beside the block, watching both channels.
module list_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  command,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_value,
  input  logic [4:0]  result_position,
  input  logic [2:0]  status,
  input  logic [4:0]  item_count,
  output int          mismatches,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import oll_pkg::*;

  logic [31:0] list_words [CAPACITY];
  int          list_len;
  result_t     expected_results [$];

  assign results_owed = expected_results.size();

  // Applies one command to the mirrored list and returns the result it should give.
  function automatic result_t apply_list_command(logic [3:0] cmd_code, logic [4:0] pos,
                                                 logic [31:0] word);
    result_t r;
    int      i;
    int      at;
    r = '{value: '0, position: '0, status: STAT_OK, count: '0};
    case (cmd_code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          if (cmd_code == CMD_PUSH_FRONT || (cmd_code == CMD_INSERT && pos == 0)) at = 0;
          else if (cmd_code == CMD_PUSH_BACK || pos >= list_len) at = list_len;
          else at = pos;
          for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = word;
          list_len++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_READ_FRONT, CMD_READ_BACK: begin
        if (list_len == 0) begin
          r.value  = VALUE_EMPTY;
          r.status = STAT_EMPTY;
        end else if (cmd_code == CMD_POP_FRONT || cmd_code == CMD_READ_FRONT) begin
          r.value = list_words[0];
          if (cmd_code == CMD_POP_FRONT) begin
            for (i = 0; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
            list_len--;
          end
        end else begin
          r.value = list_words[list_len - 1];
          if (cmd_code == CMD_POP_BACK) list_len--;
        end
      end
      CMD_REMOVE: begin
        if (pos >= list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      CMD_FIND: begin
        r.position = list_len[4:0];
        r.status   = STAT_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == word) begin
            r.position = i[4:0];
            r.status   = STAT_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // A result beat always belongs to an earlier command, so check before predicting.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: value %h status %0d",
                   $time, result_value, status);
          mismatches++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (result_value !== want.value) begin
            $display("%0t: result_value expected %h, got %h", $time, want.value, result_value);
            mismatches++;
          end
          if (result_position !== want.position) begin
            $display("%0t: result_position expected %0d, got %0d", $time, want.position,
                     result_position);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            mismatches++;
          end
          if (item_count !== want.count) begin
            $display("%0t: item_count expected %0d, got %0d", $time, want.count, item_count);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(),
                                apply_list_command(command, position, value));
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for ordered_list_engine_core: clock, reset, command stimulus and the verdict.
// Depends on oll_pkg, ordered_list_engine_core and list_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oll_pkg::*;

  localparam int          CAPACITY         = 16;
  localparam int          RANDOM_ITEMS     = 700;
  localparam int          CYCLE_LIMIT      = 500000;
  localparam int          DRAIN_CYCLES     = 2 * (CAPACITY + 1) + 10;
  localparam logic [3:0]  CMD_UNUSED_FIRST = 4'd9;
  localparam logic [3:0]  CMD_UNUSED_LAST  = 4'd15;

  typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_MIXED} mood_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  command = '0;
  logic [4:0]  position = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_value;
  logic [4:0]  result_position;
  logic [2:0]  status;
  logic [4:0]  item_count;
  int          mismatches;
  int          results_owed;
  int          cycles = 0;
  bit          steady_phase = 1'b0;

  ordered_list_engine_core #(.CAPACITY(CAPACITY), .DATA_WIDTH(32)) dut (.*);

  list_result_checker #(.CAPACITY(CAPACITY)) checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small pool of words so that finds hit and duplicates appear.
  function automatic logic [31:0] pick_value();
    logic [31:0] pool [6];
    pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_00A5};
    if ($urandom_range(0, 9) < 5) return pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, CAPACITY + 1));
  endfunction

  function automatic logic [3:0] pick_command(mood_t mood);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 4'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
    if ((mood == MOOD_GROW && r < 80) || (mood == MOOD_MIXED && r < 30)) begin
      case ($urandom_range(0, 2))
        0:       return CMD_PUSH_FRONT;
        1:       return CMD_PUSH_BACK;
        default: return CMD_INSERT;
      endcase
    end
    if (mood == MOOD_SHRINK && r < 70) begin
      case ($urandom_range(0, 2))
        0:       return CMD_POP_FRONT;
        1:       return CMD_POP_BACK;
        default: return CMD_REMOVE;
      endcase
    end
    return 4'($urandom_range(CMD_FIND, CMD_PUSH_FRONT));
  endfunction

  // Valid is lowered only when a gap follows, so it never drops and rises in one step.
  task automatic send_beat(input logic [3:0] cmd_code, input logic [4:0] pos,
                           input logic [31:0] word);
    int gap;
    gap = steady_phase ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd_code;
    position <= pos;
    value    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    int burst;
    int stall;
    forever begin
      burst = steady_phase ? 1 : $urandom_range(1, 12);
      stall = steady_phase ? 0 : idle_length();
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int    k;
    int    sent;
    int    seg_len;
    bit    paused;
    mood_t mood;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Everything that touches an empty list.
    send_beat(CMD_POP_FRONT, 5'd0, 32'h0);
    send_beat(CMD_POP_BACK, 5'd0, 32'h0);
    send_beat(CMD_READ_FRONT, 5'd0, 32'h0);
    send_beat(CMD_READ_BACK, 5'd0, 32'h0);
    send_beat(CMD_REMOVE, 5'd0, 32'h0);
    send_beat(CMD_FIND, 5'd0, 32'h0);
    // Fill to capacity with inserts at the front and the middle and pushes at the back.
    for (k = 0; k < CAPACITY; k++) begin
      send_beat(k[0] ? CMD_PUSH_BACK : CMD_INSERT,
                (k == 3) ? 5'd0 : (k == 5) ? 5'd31 : 5'(k / 2),
                (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 : k * 32'h1111_1111);
    end
    send_beat(CMD_PUSH_FRONT, 5'd0, 32'hDEAD_BEEF);
    send_beat(CMD_INSERT, 5'd4, 32'hDEAD_BEEF);
    send_beat(CMD_FIND, 5'd0, 32'h8000_0000);
    send_beat(CMD_FIND, 5'd0, 32'h1234_5678);
    send_beat(CMD_REMOVE, 5'd31, 32'h0);
    send_beat(CMD_REMOVE, 5'd7, 32'h0);
    send_beat(CMD_POP_FRONT, 5'd0, 32'h0);
    send_beat(CMD_POP_BACK, 5'd0, 32'h0);
    send_beat(CMD_UNUSED_FIRST, 5'd3, 32'h5555_5555);
    send_beat(CMD_UNUSED_LAST, 5'd31, 32'hFFFF_FFFF);
    wait_for_results();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      mood         = mood_t'($urandom_range(0, 2));
      seg_len      = $urandom_range(10, 40);
      steady_phase = ($urandom_range(0, 5) == 0);
      for (k = 0; k < seg_len; k++) send_beat(pick_command(mood), pick_position(), pick_value());
      sent += seg_len;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    steady_phase = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/oll_pkg.sv
design/oll_cell.sv
design/oll_out_buf.sv
design/ordered_list_engine_core.sv
sim/list_result_checker.sv
sim/tb_top.sv
